/* rtl/lsra_pkg.sv */
`default_nettype none
package lsra_pkg;

  // Field widths of the transaction payloads
  localparam int VALUE_W = 20;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 4;
  localparam int PREG_W  = 3;
  localparam int SPILL_W = 16;
  localparam int AREA_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPILL_AREA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_EXT   = 4'd1;

  // Spill storage areas; the unused code falls back to direct
  localparam logic [AREA_W-1:0] AREA_DIRECT   = 2'd0;
  localparam logic [AREA_W-1:0] AREA_INDIRECT = 2'd1;
  localparam logic [AREA_W-1:0] AREA_EXTERNAL = 2'd2;

  // Only this size takes a register pair
  localparam logic [SIZE_W-1:0] SIZE_PAIR = 4'd2;

  localparam logic KIND_FUNC     = 1'b0;
  localparam logic KIND_INTERVAL = 1'b1;

  typedef enum logic [2:0] {
    OUT_FREE       = 3'd0,
    OUT_EVICT      = 3'd1,
    OUT_SPILL      = 3'd2,
    OUT_PARAM      = 3'd3,
    OUT_PARAM_NONE = 3'd4,
    OUT_CLEARED    = 3'd5
  } outcome_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value_id;
    logic [POS_W-1:0]   start_req;
    logic [POS_W-1:0]   finish;
    logic [SIZE_W-1:0]  size;
    logic               param_flag;
    logic               param_reg_valid;
    logic [PREG_W-1:0]  param_reg;
  } in_item_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [PREG_W-1:0]  reg_res;
    logic               pair;
    logic [SPILL_W-1:0] spill_id;
    logic [AREA_W-1:0]  spill_area_used;
    logic               evicted_valid;
    logic [VALUE_W-1:0] evicted_value;
  } out_item_t;

  // Command broadcast from the control to every slot
  typedef struct packed {
    logic               clear;
    logic               step;
    logic [POS_W-1:0]   start_pos;
    logic               wide;
    logic               wr_en;
    logic               param_flag;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   end_pos;
  } slot_cmd_t;

  // Latest-end candidate carried along the slot chain
  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   end_pos;
    logic [VALUE_W-1:0] value;
    logic               param_flag;
  } best_t;

endpackage
`default_nettype wire

/* rtl/lsra_in_if.sv */
`default_nettype none
interface lsra_in_if;
  logic               valid;
  logic               ready;
  lsra_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lsra_out_if.sv */
`default_nettype none
interface lsra_out_if;
  logic                valid;
  logic                ready;
  lsra_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lsra_slot.sv */
`default_nettype none
module lsra_slot #(
  parameter int NUM_REGS = 8,
  parameter int IDX      = 0,
  parameter int IW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  lsra_pkg::slot_cmd_t    cmd,
  input  wire logic [IW-1:0]     wbase,
  input  wire logic              nbr_free,
  output logic                   free_now,
  input  wire logic              found_in,
  input  wire logic [IW-1:0]     found_idx_in,
  output logic                   found_out,
  output logic [IW-1:0]          found_idx_out,
  input  lsra_pkg::best_t        best_in,
  input  wire logic [IW-1:0]     best_idx_in,
  output lsra_pkg::best_t        best_out,
  output logic [IW-1:0]          best_idx_out
);
  import lsra_pkg::*;

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [IW-1:0] PREV_IDX = IW'((IDX > 0) ? IDX - 1 : 0);

  logic               busy;
  logic               param_flag;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   end_pos;
  logic               busy_eff;
  logic               cand;
  logic               take;
  logic               hit;

  // Release the register once its interval ended at or before the new start
  assign busy_eff = busy && !(end_pos <= cmd.start_pos);
  assign free_now = !busy_eff;

  // Lowest free register (or pair) chain
  assign cand          = free_now && (!cmd.wide || nbr_free);
  assign found_out     = found_in || cand;
  assign found_idx_out = found_in ? found_idx_in : MY_IDX;

  // Latest-end chain; a lower slot keeps a tie
  assign take = busy_eff && (!best_in.valid || end_pos > best_in.end_pos);
  always_comb begin
    best_out     = best_in;
    best_idx_out = best_idx_in;
    if (take) begin
      best_out.valid      = 1'b1;
      best_out.end_pos    = end_pos;
      best_out.value      = value;
      best_out.param_flag = param_flag;
      best_idx_out        = MY_IDX;
    end
  end

  // This slot is the base or the upper half of the write
  assign hit = (wbase == MY_IDX) || (cmd.wide && (IDX > 0) && (wbase == PREV_IDX));

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      param_flag <= 1'b0;
    end else if (cmd.clear) begin
      busy       <= 1'b0;
      param_flag <= 1'b0;
    end else if (cmd.step) begin
      if (cmd.wr_en && hit) begin
        busy       <= 1'b1;
        param_flag <= cmd.param_flag;
      end else begin
        busy <= busy_eff;
      end
    end
  end

  // Load the occupant payload
  always_ff @(posedge clk) begin
    if (cmd.step && cmd.wr_en && hit) begin
      value   <= cmd.value;
      end_pos <= cmd.end_pos;
    end
  end

endmodule
`default_nettype wire

/* rtl/linear_scan_register_allocator_top.sv */
`default_nettype none
// Linear-scan register allocator over NUM_REGS registers. Each input transaction
// is a function start (clears all registers) or a live interval, sorted by start
// then end; each gives exactly one result transaction, one transaction per clock
// cycle while the output does not stall, with the result registered in the output
// register. The block takes a new transaction while a result waits, as long as
// that result is taken in the same cycle. The per-cycle path is the row of
// NUM_REGS slots: the release compare, the lowest-free chain and the latest-end
// chain run through all slots, so its depth grows with NUM_REGS. Configuration:
// index 0 sets the default spill area, index 1 sends spills of size over one to
// the external area; write them only while the block is idle.
module linear_scan_register_allocator_top #(
  parameter int NUM_REGS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lsra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lsra_pkg::CFG_DATA_W-1:0] cfg_data,
  lsra_in_if.sink                              in_ch,
  lsra_out_if.source                           out_ch
);
  import lsra_pkg::*;

  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [AREA_W-1:0]  spill_area;
  logic               wide_to_external;
  logic [SPILL_W-1:0] spill_counter;
  logic               out_valid;
  out_item_t          out_data;

  in_item_t   it;
  logic       acc;
  logic       wide;
  logic       param_ok;
  logic       param_pair;
  logic       evict;
  logic       evict_pair;
  logic       do_spill;
  slot_cmd_t  cmd;
  logic [IW-1:0] wbase;
  out_item_t  res;
  logic [AREA_W-1:0] area;

  logic          free_now  [NUM_REGS];
  logic          found     [NUM_REGS+1];
  logic [IW-1:0] found_idx [NUM_REGS+1];
  best_t         best      [NUM_REGS+1];
  logic [IW-1:0] best_idx  [NUM_REGS+1];

  assign it  = in_ch.data;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign wide = (it.size == SIZE_PAIR);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_area       <= AREA_DIRECT;
      wide_to_external <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SPILL_AREA: spill_area <= cfg_data;
        CFG_WIDE_EXT:   wide_to_external <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Chain heads
  assign found[0]     = 1'b0;
  assign found_idx[0] = '0;
  assign best[0]      = '0;
  assign best_idx[0]  = '0;

  // Row of register slots
  for (genvar i = 0; i < NUM_REGS; i++) begin : g_slot
    logic nbr_free;
    if (i < NUM_REGS - 1) begin : g_nbr
      assign nbr_free = free_now[i+1];
    end else begin : g_top
      assign nbr_free = 1'b0;
    end
    lsra_slot #(
      .NUM_REGS(NUM_REGS),
      .IDX     (i),
      .IW      (IW)
    ) u_slot (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .wbase        (wbase),
      .nbr_free     (nbr_free),
      .free_now     (free_now[i]),
      .found_in     (found[i]),
      .found_idx_in (found_idx[i]),
      .found_out    (found[i+1]),
      .found_idx_out(found_idx[i+1]),
      .best_in      (best[i]),
      .best_idx_in  (best_idx[i]),
      .best_out     (best[i+1]),
      .best_idx_out (best_idx[i+1])
    );
  end

  // Decide placement
  assign param_ok   = it.param_reg_valid && (int'(it.param_reg) < NUM_REGS);
  assign param_pair = wide && (int'(it.param_reg) + 1 < NUM_REGS);
  assign evict      = !found[NUM_REGS] && best[NUM_REGS].valid &&
                      (best[NUM_REGS].end_pos > it.finish) && !best[NUM_REGS].param_flag;
  assign evict_pair = wide && (int'(best_idx[NUM_REGS]) + 1 < NUM_REGS);
  assign do_spill   = !it.param_flag && !found[NUM_REGS] && !evict;

  always_comb begin
    if (it.param_flag) begin
      wbase = IW'(it.param_reg);
    end else if (found[NUM_REGS]) begin
      wbase = found_idx[NUM_REGS];
    end else begin
      wbase = best_idx[NUM_REGS];
    end
  end

  // Broadcast the slot command
  always_comb begin
    cmd.clear      = acc && (it.kind == KIND_FUNC);
    cmd.step       = acc && (it.kind == KIND_INTERVAL);
    cmd.start_pos  = it.start_req;
    cmd.wide       = wide;
    cmd.wr_en      = it.param_flag ? param_ok : (found[NUM_REGS] || evict);
    cmd.param_flag = it.param_flag;
    cmd.value      = it.value_id;
    cmd.end_pos    = it.finish;
  end

  // Pick the spill area
  always_comb begin
    area = (spill_area > AREA_EXTERNAL) ? AREA_DIRECT : spill_area;
    if (wide_to_external && (it.size > 4'd1)) begin
      area = AREA_EXTERNAL;
    end
  end

  // Build the result
  always_comb begin
    res = '0;
    if (it.kind == KIND_FUNC) begin
      res.outcome = OUT_CLEARED;
    end else if (it.param_flag) begin
      if (param_ok) begin
        res.outcome = OUT_PARAM;
        res.reg_res = it.param_reg;
        res.pair    = param_pair;
      end else begin
        res.outcome = OUT_PARAM_NONE;
      end
    end else if (found[NUM_REGS]) begin
      res.outcome = OUT_FREE;
      res.reg_res = PREG_W'(wbase);
      res.pair    = wide;
    end else if (evict) begin
      res.outcome       = OUT_EVICT;
      res.reg_res       = PREG_W'(wbase);
      res.pair          = evict_pair;
      res.evicted_valid = 1'b1;
      res.evicted_value = best[NUM_REGS].value;
    end else begin
      res.outcome         = OUT_SPILL;
      res.spill_id        = spill_counter;
      res.spill_area_used = area;
    end
  end

  // Advance the spill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_counter <= '0;
    end else if (acc && (it.kind == KIND_INTERVAL) && do_spill) begin
      spill_counter <= spill_counter + 1'b1;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule
`default_nettype wire
